// ===== rtl/core/line_plane_intersect_core_assert.svh =====
// assertion helpers shared by the line/plane intersection core
`ifndef LINE_PLANE_INTERSECT_CORE_ASSERT_SVH
`define LINE_PLANE_INTERSECT_CORE_ASSERT_SVH

// same-cycle implication
`define LPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpi check failed");

// next-cycle implication
`define LPI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpi check failed");

`endif

// ===== rtl/core/lpi_pkg.sv =====
package lpi_pkg;

   localparam int CW    = 32;          // coordinate width
   localparam int AX    = 3;           // axes
   localparam int LANES = 4;           // three hit axes and t
   localparam int TL    = 3;           // lane that computes t
   localparam int DIFW  = CW + 1;      // difference of two coordinates
   localparam int PRW   = DIFW + CW;   // one dot product term
   localparam int NW    = PRW + 2;     // sum of three terms
   localparam int MW    = NW - 1;      // magnitude of a sum
   localparam int DMW   = DIFW;        // magnitude of a direction component
   localparam int NCH   = 3;           // slices of the numerator magnitude
   localparam int CHW   = MW / NCH;    // slice width
   localparam int PPW   = CHW + DMW;   // partial product width
   localparam int XW    = MW + DMW;    // dividend width
   localparam int QW    = 34;          // quotient bits kept, larger means clipped
   localparam int SUMW  = QW + 3;      // signed offset plus start point
   localparam int IN_W  = 12 * CW;
   localparam int OUT_W = 4 * CW;

   localparam logic signed [SUMW-1:0] HI_LIM = (SUMW'(1) << (CW - 1)) - SUMW'(1);
   localparam logic signed [SUMW-1:0] LO_LIM = SUMW'(0) - (SUMW'(1) << (CW - 1));

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic                   par;
      logic [LANES-1:0]       neg;
      logic [AX-1:0][CW-1:0]  s;
   } lpi_side_type;

endpackage

// ===== rtl/core/lpi_div.sv =====
`include "line_plane_intersect_core_assert.svh"

module lpi_div import lpi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [LANES-1:0][XW-1:0]   in_x,
   input  logic [MW-1:0]              in_d,
   input  lpi_side_type               in_side,
   output logic                       out_valid,
   output logic [LANES-1:0][QW-1:0]   out_q,
   output logic [LANES-1:0]           out_ovf,
   output lpi_side_type               out_side
);

   logic [QW:0]                 v_ff;
   logic [LANES-1:0][MW-1:0]    rem_ff  [QW+1];
   logic [LANES-1:0][QW-1:0]    lo_ff   [QW+1];
   logic [LANES-1:0][QW-1:0]    q_ff    [QW+1];
   logic [LANES-1:0]            ovf_ff  [QW+1];
   logic [MW-1:0]               d_ff    [QW+1];
   lpi_side_type                side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   // load: quotient fits in QW bits only if the upper dividend is below the divisor
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= MW'(in_x[l][XW-1:QW]);
            lo_ff[0][l]  <= in_x[l][QW-1:0];
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= MW'(in_x[l][XW-1:QW]) >= in_d;
         end
         d_ff[0]    <= in_d;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [LANES-1:0][MW-1:0] rem_in;
      logic [LANES-1:0][QW-1:0] q_in;
      logic [MW:0]              trial;
      logic [MW:0]              diff;
      logic                     ge;

      always_comb begin
         trial = '0;
         diff  = '0;
         ge    = 1'b0;
         for (int l = 0; l < LANES; l++) begin
            trial     = {rem_ff[j][l], lo_ff[j][l][QW-1]};
            diff      = trial - {1'b0, d_ff[j]};
            ge        = trial >= {1'b0, d_ff[j]};
            rem_in[l] = ge ? diff[MW-1:0] : trial[MW-1:0];
            q_in[l]   = {q_ff[j][l][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= rem_in;
            q_ff[j+1]    <= q_in;
            for (int l = 0; l < LANES; l++) begin
               lo_ff[j+1][l] <= {lo_ff[j][l][QW-2:0], 1'b0};
            end
            ovf_ff[j+1]  <= ovf_ff[j];
            d_ff[j+1]    <= d_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_q     = q_ff[QW];
   assign out_ovf   = ovf_ff[QW];
   assign out_side  = side_ff[QW];

   for (genvar l = 0; l < LANES; l++) begin : g_chk
      `LPI_ASSERT_IMP(rem_below_div, clock, reset, v_ff[QW] && !ovf_ff[QW][l], rem_ff[QW][l] < d_ff[QW])
   end
   `LPI_ASSERT_IMP(zero_div_ovf, clock, reset, v_ff[QW] && d_ff[QW] == '0, &ovf_ff[QW])
   `LPI_ASSERT_NXT(stall_holds, clock, reset, !en, $stable(v_ff))

endmodule

// ===== rtl/core/line_plane_intersect_core.sv =====
// line/plane intersection core
// req channel: one segment per transfer, req_tdata carries twelve signed fixed-point words:
//   plane point x/y/z, plane normal x/y/z, line start x/y/z, line end x/y/z
// rsp channel: one result per segment, rsp_tdata holds hit x/y/z and t, rsp_tuser the
//   parallel and saturated flags
// num and den dot products are exact; t = num/den and hit = start + dir*num/den are
//   truncated toward zero and clipped to 32 bits
// the pipeline has 42 register stages in all
// throughput: one segment per cycle unless a stall holds the pipeline; six arithmetic stages
//   feed a load stage and a 34-stage restoring divider that retires one quotient bit per
//   stage in four lanes sharing the divisor, then one output register
// reset clears all valid bits; data registers are not reset
// when rsp_tready is low with a result waiting, the whole pipeline holds and req_tready
//   drops; nothing is lost or repeated, and it resumes when the result is taken
`include "line_plane_intersect_core_assert.svh"

module line_plane_intersect_core import lpi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // plane_point_x, plane_point_y, plane_point_z, normal_x, normal_y, normal_z,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [IN_W-1:0]   req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // hit_x, hit_y, hit_z, param_t
   output logic [OUT_W-1:0]  rsp_tdata,
   // parallel, saturated
   output logic [1:0]        rsp_tuser
);

   logic en;
   logic [5:0] vp_ff;

   coord_type pp_w [AX];
   coord_type nv_w [AX];
   coord_type sv_w [AX];
   coord_type ev_w [AX];

   logic signed [DIFW-1:0] pd1_ff [AX];
   logic signed [DIFW-1:0] dir1_ff [AX];
   coord_type              nv1_ff [AX];
   coord_type              s1_ff [AX];

   logic signed [PRW-1:0]  prn2_ff [AX];
   logic signed [PRW-1:0]  prd2_ff [AX];
   logic signed [DIFW-1:0] dir2_ff [AX];
   coord_type              s2_ff [AX];

   logic signed [NW-1:0]   num3_ff;
   logic signed [NW-1:0]   den3_ff;
   logic signed [DIFW-1:0] dir3_ff [AX];
   coord_type              s3_ff [AX];

   logic [NW-1:0]          nneg_w;
   logic [NW-1:0]          dneg_w;
   logic [MW-1:0]          nm4_ff;
   logic [MW-1:0]          dm4_ff;
   logic                   sn4_ff;
   logic                   sd4_ff;
   logic                   par4_ff;
   logic [DMW-1:0]         dmag4_ff [AX];
   logic [AX-1:0]          dneg4_ff;
   coord_type              s4_ff [AX];

   logic [PPW-1:0]         pp5_ff [AX][NCH];
   logic [MW-1:0]          nm5_ff;
   logic [MW-1:0]          dm5_ff;
   lpi_side_type           side5_in;
   lpi_side_type           side5_ff;

   logic [LANES-1:0][XW-1:0] x6_ff;
   logic [MW-1:0]          dm6_ff;
   lpi_side_type           side6_ff;

   logic                   dv;
   logic [LANES-1:0][QW-1:0] dq;
   logic [LANES-1:0]       dovf;
   lpi_side_type           dside;

   logic                   rsp_v_ff;
   logic [OUT_W-1:0]       data_ff;
   logic [OUT_W-1:0]       data_in;
   logic                   par_ff;
   logic                   sat_ff;
   logic                   sat_in;
   logic                   at_lim;

   assign en         = !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < AX; i++) begin
         pp_w[i] = coord_type'(req_tdata[i*CW +: CW]);
         nv_w[i] = coord_type'(req_tdata[(AX+i)*CW +: CW]);
         sv_w[i] = coord_type'(req_tdata[(2*AX+i)*CW +: CW]);
         ev_w[i] = coord_type'(req_tdata[(3*AX+i)*CW +: CW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff    <= '0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         vp_ff    <= {vp_ff[4:0], req_tvalid};
         rsp_v_ff <= dv;
      end
   end

   // differences, products, sums, magnitudes
   assign nneg_w = -num3_ff;
   assign dneg_w = -den3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            pd1_ff[i]  <= DIFW'(pp_w[i]) - DIFW'(sv_w[i]);
            dir1_ff[i] <= DIFW'(ev_w[i]) - DIFW'(sv_w[i]);
            nv1_ff[i]  <= nv_w[i];
            s1_ff[i]   <= sv_w[i];

            prn2_ff[i] <= PRW'(pd1_ff[i]) * PRW'(nv1_ff[i]);
            prd2_ff[i] <= PRW'(dir1_ff[i]) * PRW'(nv1_ff[i]);
            dir2_ff[i] <= dir1_ff[i];
            s2_ff[i]   <= s1_ff[i];

            dir3_ff[i] <= dir2_ff[i];
            s3_ff[i]   <= s2_ff[i];

            dneg4_ff[i] <= dir3_ff[i][DIFW-1];
            dmag4_ff[i] <= dir3_ff[i][DIFW-1] ? DMW'(-dir3_ff[i]) : DMW'(dir3_ff[i]);
            s4_ff[i]    <= s3_ff[i];
         end
         num3_ff <= NW'(prn2_ff[0]) + NW'(prn2_ff[1]) + NW'(prn2_ff[2]);
         den3_ff <= NW'(prd2_ff[0]) + NW'(prd2_ff[1]) + NW'(prd2_ff[2]);

         sn4_ff  <= num3_ff[NW-1];
         sd4_ff  <= den3_ff[NW-1];
         nm4_ff  <= num3_ff[NW-1] ? nneg_w[MW-1:0] : num3_ff[MW-1:0];
         dm4_ff  <= den3_ff[NW-1] ? dneg_w[MW-1:0] : den3_ff[MW-1:0];
         par4_ff <= den3_ff == '0;
      end
   end

   always_comb begin
      side5_in.par = par4_ff;
      for (int i = 0; i < AX; i++) begin
         side5_in.neg[i] = dneg4_ff[i] ^ sn4_ff ^ sd4_ff;
         side5_in.s[i]   = s4_ff[i];
      end
      side5_in.neg[TL] = sn4_ff ^ sd4_ff;
   end

   // numerator magnitude times direction magnitude, in slices
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            for (int k = 0; k < NCH; k++) begin
               pp5_ff[i][k] <= PPW'(nm4_ff[k*CHW +: CHW]) * PPW'(dmag4_ff[i]);
            end
         end
         nm5_ff   <= nm4_ff;
         dm5_ff   <= dm4_ff;
         side5_ff <= side5_in;

         for (int i = 0; i < AX; i++) begin
            x6_ff[i] <= XW'(pp5_ff[i][0]) + (XW'(pp5_ff[i][1]) << CHW)
                      + (XW'(pp5_ff[i][2]) << (2 * CHW));
         end
         x6_ff[TL] <= XW'(nm5_ff) << FRAC_BITS;
         dm6_ff    <= dm5_ff;
         side6_ff  <= side5_ff;
      end
   end

   lpi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vp_ff[5]),
      .in_x      (x6_ff),
      .in_d      (dm6_ff),
      .in_side   (side6_ff),
      .out_valid (dv),
      .out_q     (dq),
      .out_ovf   (dovf),
      .out_side  (dside)
   );

   // sign, offset from start, clip; all zero when parallel
   always_comb begin
      logic [QW:0]             mag;
      logic signed [SUMW-1:0]  off;
      logic signed [SUMW-1:0]  sum;
      logic                    hi;
      logic                    lo;
      data_in = '0;
      sat_in  = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         mag = dovf[l] ? {1'b1, {QW{1'b0}}} : {1'b0, dq[l]};
         off = dside.neg[l] ? SUMW'(0) - SUMW'(mag) : SUMW'(mag);
         sum = off;
         if (l < AX) begin
            sum = off + SUMW'(coord_type'(dside.s[l[1:0]]));
         end
         hi = sum > HI_LIM;
         lo = sum < LO_LIM;
         data_in[l*CW +: CW] = hi ? HI_LIM[CW-1:0] : (lo ? LO_LIM[CW-1:0] : sum[CW-1:0]);
         sat_in = sat_in | hi | lo;
      end
      if (dside.par) begin
         data_in = '0;
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         par_ff  <= dside.par;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {sat_ff, par_ff};

   always_comb begin
      at_lim = 1'b0;
      for (int l = 0; l < 4; l++) begin
         at_lim = at_lim || rsp_tdata[l*CW +: CW] == HI_LIM[CW-1:0]
                         || rsp_tdata[l*CW +: CW] == LO_LIM[CW-1:0];
      end
   end

   `LPI_ASSERT_IMP(par_gives_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])
   `LPI_ASSERT_IMP(sat_at_limit, clock, reset, rsp_tvalid && rsp_tuser[1], at_lim)
   `LPI_ASSERT_IMP(stall_only_full, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

endmodule
